>>> hw/rtl/fpd_pkg.sv
`default_nettype none
package fpd_pkg;

  localparam int unsigned NumDigits = 20;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharPoint = 8'h2e;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharNone  = 8'h00;

  typedef enum logic [1:0] {
    StatusChar     = 2'd0,
    StatusLenOnly  = 2'd1,
    StatusNoRoom   = 2'd2,
    StatusBadPlace = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  places;
    logic        negative;
    logic        length_only;
    logic [7:0]  room;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [1:0] status;
    logic [5:0] length;
  } out_item_t;

  typedef struct packed {
    logic [NumDigits-1:0][3:0] digits;
    logic [5:0]                places;
    logic                      negative;
    logic                      length_only;
    logic [7:0]                room;
  } bcd_item_t;

  typedef struct packed {
    logic [NumDigits-1:0][3:0] digits;
    logic [5:0]                places;
    logic [5:0]                int_len;
    logic [5:0]                need;
    logic                      negative;
    status_e                   status;
  } job_t;

endpackage
`default_nettype wire

>>> hw/rtl/fpd_bcd_pipe.sv
`default_nettype none
// Double-dabble conversion, eight bits of the value per stage, registered.
module fpd_bcd_pipe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  fpd_pkg::in_item_t in_item_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output fpd_pkg::bcd_item_t out_item_o,
  input  logic              out_stall_i
);

  localparam int unsigned Stages = 8;
  localparam int unsigned BitsPerStage = 8;

  typedef struct packed {
    logic [fpd_pkg::NumDigits-1:0][3:0] digits;
    logic [63:0]                        rest;
    logic [5:0]                         places;
    logic                               negative;
    logic                               length_only;
    logic [7:0]                         room;
  } work_t;

  logic [Stages:0] valid_q;
  work_t           work_q [Stages+1];
  logic [Stages:0] stall;

  // Stage 0 is the input register.
  assign stall[Stages] = valid_q[Stages] & out_stall_i;
  for (genvar s = Stages - 1; s >= 0; s--) begin : g_stall
    assign stall[s] = valid_q[s] & stall[s+1];
  end
  assign in_stall_o = stall[0];

  function automatic work_t dabble(work_t w);
    work_t r;
    logic  top;
    r = w;
    for (int b = 0; b < BitsPerStage; b++) begin
      for (int d = 0; d < fpd_pkg::NumDigits; d++) begin
        if (r.digits[d] >= 4'd5) r.digits[d] = r.digits[d] + 4'd3;
      end
      top = r.rest[63];
      r.rest = {r.rest[62:0], 1'b0};
      r.digits = {r.digits[fpd_pkg::NumDigits-1][2:0], r.digits[fpd_pkg::NumDigits-2:0], top};
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (!stall[0]) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall[0] && in_valid_i) begin
      work_q[0].digits      <= '0;
      work_q[0].rest        <= in_item_i.value;
      work_q[0].places      <= in_item_i.places;
      work_q[0].negative    <= in_item_i.negative;
      work_q[0].length_only <= in_item_i.length_only;
      work_q[0].room        <= in_item_i.room;
    end
  end

  for (genvar s = 1; s <= Stages; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (!stall[s]) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (!stall[s] && valid_q[s-1]) begin
        work_q[s] <= dabble(work_q[s-1]);
      end
    end
  end

  assign out_valid_o             = valid_q[Stages];
  assign out_item_o.digits       = work_q[Stages].digits;
  assign out_item_o.places       = work_q[Stages].places;
  assign out_item_o.negative     = work_q[Stages].negative;
  assign out_item_o.length_only  = work_q[Stages].length_only;
  assign out_item_o.room         = work_q[Stages].room;

endmodule
`default_nettype wire

>>> hw/rtl/fpd_measure.sv
`default_nettype none
// Finds the digit count, the needed length and the result status.
module fpd_measure (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  fpd_pkg::bcd_item_t in_item_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output fpd_pkg::job_t      out_job_o,
  input  logic               out_stall_i,
  input  logic [5:0]         max_places_i
);

  logic               valid_q;
  logic               valid2_q;
  fpd_pkg::bcd_item_t item_q;
  logic [4:0]         ndig_q;
  fpd_pkg::job_t      job_q;
  logic [4:0]         ndig;
  logic [5:0]         int_len;
  logic [6:0]         need;
  logic               stall1;

  assign in_stall_o = valid_q & stall1;
  assign stall1     = valid2_q & out_stall_i;

  always_comb begin
    ndig = '0;
    for (int d = 0; d < fpd_pkg::NumDigits; d++) begin
      if (in_item_i.digits[d] != 4'd0) ndig = 5'(d + 1);
    end
  end

  always_comb begin
    int_len = ({1'b0, item_q.places} >= {2'b0, ndig_q}) ? 6'd1
              : ({1'b0, ndig_q} - item_q.places);
    need = 7'(item_q.negative) + 7'(int_len)
           + ((item_q.places != 6'd0) ? 7'(item_q.places) + 7'd1 : 7'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      if (!in_stall_o) valid_q <= in_valid_i;
      if (!stall1) valid2_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
      ndig_q <= ndig;
    end
    if (!stall1 && valid_q) begin
      job_q.digits   <= item_q.digits;
      job_q.places   <= item_q.places;
      job_q.int_len  <= int_len;
      job_q.negative <= item_q.negative;
      if (item_q.places > max_places_i) begin
        job_q.status <= fpd_pkg::StatusBadPlace;
        job_q.need   <= 6'd0;
      end else begin
        job_q.need <= need[5:0];
        if (item_q.length_only) job_q.status <= fpd_pkg::StatusLenOnly;
        else if ({1'b0, item_q.room} < {2'b0, need}) job_q.status <= fpd_pkg::StatusNoRoom;
        else job_q.status <= fpd_pkg::StatusChar;
      end
    end
  end

  assign out_valid_o = valid2_q;
  assign out_job_o   = job_q;

endmodule
`default_nettype wire

>>> hw/rtl/fpd_emit.sv
`default_nettype none
// Turns a job into characters, one per unstalled cycle, via an output register.
module fpd_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  fpd_pkg::job_t      in_job_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output fpd_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);

  logic               busy_q;
  fpd_pkg::job_t      job_q;
  logic [5:0]         pos_q;
  logic               ovalid_q;
  fpd_pkg::out_item_t oitem_q;
  logic               oready;
  logic               done;
  fpd_pkg::out_item_t nxt;
  logic [5:0]         idx;
  logic [6:0]         frac_pos;

  assign oready     = !ovalid_q || !out_stall_i;
  assign in_stall_o = busy_q;

  always_comb begin
    nxt.length = job_q.need;
    nxt.status = job_q.status;
    nxt.character = fpd_pkg::CharNone;
    idx = '0;
    frac_pos = '0;
    if (job_q.status != fpd_pkg::StatusChar) begin
      nxt.last = 1'b1;
    end else begin
      nxt.last = (pos_q + 6'd1) == job_q.need;
      if (job_q.negative && pos_q == 6'd0) begin
        nxt.character = fpd_pkg::CharMinus;
      end else begin
        frac_pos = 7'(pos_q) - 7'(job_q.negative);
        if (frac_pos < 7'(job_q.int_len)) begin
          idx = 6'(7'(job_q.places) + 7'(job_q.int_len) - 7'd1 - frac_pos);
          nxt.character = fpd_pkg::CharZero
                          + ((idx < 6'(fpd_pkg::NumDigits))
                             ? 8'(job_q.digits[idx[4:0]]) : 8'd0);
        end else if (frac_pos == 7'(job_q.int_len)) begin
          nxt.character = fpd_pkg::CharPoint;
        end else begin
          idx = 6'(7'(job_q.places) + 7'(job_q.int_len) - frac_pos);
          nxt.character = fpd_pkg::CharZero
                          + ((idx < 6'(fpd_pkg::NumDigits))
                             ? 8'(job_q.digits[idx[4:0]]) : 8'd0);
        end
      end
    end
  end

  assign done = busy_q && oready && nxt.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      pos_q    <= '0;
    end else begin
      if (oready) ovalid_q <= busy_q;
      if (!busy_q && in_valid_i) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q && oready) begin
        pos_q <= pos_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i) job_q <= in_job_i;
    if (oready && busy_q) oitem_q <= nxt;
  end

  assign out_valid_o = ovalid_q;
  assign out_item_o  = oitem_q;

`ifndef SYNTH
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !busy_q) else $error("emitter stayed busy after last");
  a_nonchar_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && job_q.status != fpd_pkg::StatusChar) |-> nxt.last)
    else $error("status result not last");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> ovalid_q) else $error("result dropped");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/fixed_point_decimal_to_ascii.sv
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | fpd_pkg::in_item_t
// out     | output    | out_valid_o/out_stall_i | fpd_pkg::out_item_t
// An item passes an input register, 8 conversion stages, 2 measure stages, then the emitter.
// The emitter gives one character per cycle while the output is not stalled. It takes no
// new job while busy and loads the next one only after the last character or status result.
// Reset is asynchronous and active low and clears all valid bits.
// A stall on the output holds the emitter; earlier stages fill up and then hold.
// Nothing is lost or repeated.
module fixed_point_decimal_to_ascii #(
  parameter int unsigned MAX_PLACES = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  fpd_pkg::in_item_t  in_item_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output fpd_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);

  logic               bcd_valid, bcd_stall, job_valid, job_stall;
  fpd_pkg::bcd_item_t bcd_item;
  fpd_pkg::job_t      job;

  fpd_bcd_pipe u_bcd (
    .clk_i, .rst_ni, .in_valid_i, .in_item_i, .in_stall_o,
    .out_valid_o(bcd_valid), .out_item_o(bcd_item), .out_stall_i(bcd_stall)
  );

  fpd_measure u_measure (
    .clk_i, .rst_ni, .in_valid_i(bcd_valid), .in_item_i(bcd_item),
    .in_stall_o(bcd_stall), .out_valid_o(job_valid), .out_job_o(job),
    .out_stall_i(job_stall), .max_places_i(6'(MAX_PLACES))
  );

  fpd_emit u_emit (
    .clk_i, .rst_ni, .in_valid_i(job_valid), .in_job_i(job),
    .in_stall_o(job_stall), .out_valid_o, .out_item_o, .out_stall_i
  );

endmodule
`default_nettype wire
